// ===== src/ppgdc_pkg.sv =====
// Package: shared constants, codes and control structs for the PPG DC removal block.
`timescale 1ns / 1ps
package ppgdc_pkg;

  localparam int RAW_W       = 16;
  localparam int ALPHA_W     = 16;
  localparam int THR_W       = 24;
  localparam int LEVEL_INT_W = 24;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 24;
  localparam int OUT_W       = 26;
  localparam int OUT_FRAC    = 8;
  localparam int MEM_W       = 32;
  localparam int COEF_FRAC   = 16;
  localparam int LP_COEF_W   = 17;

  localparam logic [LP_COEF_W-1:0] LP_B = 17'd16072;
  localparam logic [LP_COEF_W-1:0] LP_A = 17'd33392;

  localparam logic [ALPHA_W-1:0] ALPHA_RST = 16'd62259;
  localparam logic [THR_W-1:0]   THR_RST   = 24'd70000;
  localparam int POWER_MAX_RST   = 15;
  localparam int POWER_START_RST = 8;

  localparam int OUT_MAX = (1 << (OUT_W - 1)) - 1;
  localparam int OUT_MIN = -(1 << (OUT_W - 1));

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DC_ALPHA        = 8'd0,
    REG_BIAS_THRESHOLD  = 8'd1,
    REG_RED_POWER_MAX   = 8'd2,
    REG_RED_POWER_START = 8'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LVL,
    ST_AC,
    ST_LPM,
    ST_LPS,
    ST_BIAS,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic mul;
    logic lvl;
    logic ac;
  } lane_ctl_t;

  typedef struct packed {
    logic pre;
    logic lpm;
    logic lps;
    logic bias;
    logic done_sample;
    logic done_tick;
  } merge_ctl_t;

endpackage

// ===== src/ppgdc_in_if.sv =====
// Interface: input channel carrying sample and bias-tick commands.
`timescale 1ns / 1ps
interface ppgdc_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] ir_raw;
  logic [15:0] red_raw;

  modport source (output valid, output command, output ir_raw, output red_raw, input ready);
  modport sink   (input valid, input command, input ir_raw, input red_raw, output ready);
endinterface

// ===== src/ppgdc_out_if.sv =====
// Interface: result channel with AC values, filtered beat signal and red power.
`timescale 1ns / 1ps
interface ppgdc_out_if #(parameter int POWER_BITS = 4);
  logic                   valid;
  logic                   ready;
  logic signed [25:0]     ir_ac;
  logic signed [25:0]     red_ac;
  logic signed [25:0]     beat_filtered;
  logic [POWER_BITS-1:0]  red_led_power;
  logic                   power_changed;

  modport source (output valid, output ir_ac, output red_ac, output beat_filtered,
                  output red_led_power, output power_changed, input ready);
  modport sink   (input valid, input ir_ac, input red_ac, input beat_filtered,
                  input red_led_power, input power_changed, output ready);
endinterface

// ===== src/ppgdc_cfg_if.sv =====
// Interface: configuration write channel (register index and data).
`timescale 1ns / 1ps
interface ppgdc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  idx;
  logic [23:0] data;

  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

// ===== src/ppgdc_dc_lane.sv =====
// DC-removal lane: one channel's IIR level and its AC output.
`timescale 1ns / 1ps
module ppgdc_dc_lane #(
  parameter int LEVEL_FRAC_BITS = 16
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  ppgdc_pkg::lane_ctl_t                             ctl,
  input  logic [ppgdc_pkg::ALPHA_W-1:0]                    alpha,
  input  logic [ppgdc_pkg::RAW_W-1:0]                      raw,
  output logic [ppgdc_pkg::LEVEL_INT_W+LEVEL_FRAC_BITS-1:0] level,
  output logic signed [ppgdc_pkg::OUT_W-1:0]               ac
);
  import ppgdc_pkg::*;

  localparam int LB    = LEVEL_INT_W + LEVEL_FRAC_BITS;
  localparam int LO_W  = 24;
  localparam int HI_W  = LB - LO_W;
  localparam int PLO_W = ALPHA_W + LO_W;
  localparam int PHI_W = ALPHA_W + HI_W;
  localparam int PW    = ALPHA_W + LB;
  localparam int SH    = LEVEL_FRAC_BITS - OUT_FRAC;
  localparam int RW    = LB + 2;

  logic [LB-1:0]           level_r;
  logic [LB-1:0]           old_r;
  logic [PLO_W-1:0]        pp_lo_r;
  logic [PHI_W-1:0]        pp_hi_r;
  logic signed [OUT_W-1:0] ac_r;

  logic [PW-1:0]           prod_full;
  logic [LB-1:0]           prod;
  logic [LB-1:0]           xin;
  logic [LB:0]             sum;
  logic [LB-1:0]           lvl_nxt;
  logic signed [RW-1:0]    diff;
  logic signed [RW-1:0]    rnd;
  logic signed [OUT_W-1:0] ac_c;

  // alpha * level split in two partial products, summed in the next cycle
  always_comb begin
    prod_full = PW'(pp_lo_r) + {pp_hi_r, {LO_W{1'b0}}} + PW'(1 << (COEF_FRAC - 1));
    prod      = prod_full[PW-1:COEF_FRAC];
    xin       = LB'(raw) << LEVEL_FRAC_BITS;
    sum       = {1'b0, xin} + {1'b0, prod};
    lvl_nxt   = sum[LB] ? {LB{1'b1}} : sum[LB-1:0];
    diff      = $signed({2'b00, level_r}) - $signed({2'b00, old_r});
  end

  generate
    if (SH == 0) begin : g_noshift
      assign rnd = diff;
    end else begin : g_shift
      assign rnd = (diff + RW'(1 << (SH - 1))) >>> SH;
    end
  endgenerate

  always_comb begin
    if (rnd > RW'(OUT_MAX)) begin
      ac_c = OUT_W'(OUT_MAX);
    end else if (rnd < RW'(OUT_MIN)) begin
      ac_c = OUT_W'(OUT_MIN);
    end else begin
      ac_c = rnd[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
    end else if (ctl.lvl) begin
      level_r <= lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      pp_lo_r <= PLO_W'(alpha) * PLO_W'(level_r[LO_W-1:0]);
      pp_hi_r <= PHI_W'(alpha) * PHI_W'(level_r[LB-1:LO_W]);
      old_r   <= level_r;
    end
    if (ctl.ac) begin
      ac_r <= ac_c;
    end
  end

  assign level = level_r;
  assign ac    = ac_r;

endmodule

// ===== src/ppgdc_merge.sv =====
// Merge stage: Butterworth low-pass on negated IR AC and red LED bias follower.
`timescale 1ns / 1ps
module ppgdc_merge #(
  parameter int LEVEL_FRAC_BITS = 16,
  parameter int POWER_BITS      = 4
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  ppgdc_pkg::merge_ctl_t                            ctl,
  input  logic signed [ppgdc_pkg::OUT_W-1:0]               ir_ac,
  input  logic [ppgdc_pkg::LEVEL_INT_W+LEVEL_FRAC_BITS-1:0] ir_level,
  input  logic [ppgdc_pkg::LEVEL_INT_W+LEVEL_FRAC_BITS-1:0] red_level,
  input  logic [ppgdc_pkg::THR_W-1:0]                      thr,
  input  logic [POWER_BITS-1:0]                            power_max,
  input  logic                                             cfg_load,
  input  logic [POWER_BITS-1:0]                            cfg_power,
  output logic signed [ppgdc_pkg::OUT_W-1:0]               filt,
  output logic [POWER_BITS-1:0]                            power_nxt,
  output logic                                             changed
);
  import ppgdc_pkg::*;

  localparam int LB  = LEVEL_INT_W + LEVEL_FRAC_BITS;
  localparam int SW  = LP_COEF_W + 1 + MEM_W + 1;
  localparam int FSW = MEM_W + 1;
  localparam logic signed [SW-1:0] M_HI = SW'($signed(32'h7fff_ffff));
  localparam logic signed [SW-1:0] M_LO = SW'($signed(32'h8000_0000));

  logic signed [MEM_W-1:0] prev_r;
  logic signed [MEM_W-1:0] mem_r;
  logic signed [SW-1:0]    pa_r;
  logic signed [SW-1:0]    pb_r;
  logic                    up_r;
  logic                    dn_r;
  logic [POWER_BITS-1:0]   power_r;

  logic signed [OUT_W-1:0] x_c;
  logic signed [SW-1:0]    s_c;
  logic signed [SW-1:0]    m_c;
  logic signed [MEM_W-1:0] mem_c;
  logic signed [FSW-1:0]   fsum;
  logic [LB-1:0]           thr_ext;
  logic                    up_c;
  logic                    dn_c;

  always_comb begin
    x_c   = (ir_ac == OUT_W'(OUT_MIN)) ? OUT_W'(OUT_MAX) : -ir_ac;
    s_c   = pa_r + pb_r + SW'(1 << (COEF_FRAC - 1));
    m_c   = s_c >>> COEF_FRAC;
    if (m_c > M_HI) begin
      mem_c = MEM_W'(M_HI);
    end else if (m_c < M_LO) begin
      mem_c = MEM_W'(M_LO);
    end else begin
      mem_c = m_c[MEM_W-1:0];
    end
    fsum = $signed({prev_r[MEM_W-1], prev_r}) + $signed({mem_r[MEM_W-1], mem_r});
    if (fsum > FSW'(OUT_MAX)) begin
      filt = OUT_W'(OUT_MAX);
    end else if (fsum < FSW'(OUT_MIN)) begin
      filt = OUT_W'(OUT_MIN);
    end else begin
      filt = fsum[OUT_W-1:0];
    end
  end

  always_comb begin
    thr_ext = {thr, {LEVEL_FRAC_BITS{1'b0}}};
    up_c    = (ir_level > red_level) && ((ir_level - red_level) > thr_ext);
    dn_c    = (red_level > ir_level) && ((red_level - ir_level) > thr_ext);
  end

  always_comb begin
    power_nxt = power_r;
    changed   = 1'b0;
    if (ctl.done_tick) begin
      if (up_r && (power_r < power_max)) begin
        power_nxt = power_r + 1'b1;
        changed   = 1'b1;
      end else if (dn_r && (power_r != '0)) begin
        power_nxt = power_r - 1'b1;
        changed   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      power_r <= POWER_BITS'(POWER_START_RST);
      up_r    <= 1'b0;
      dn_r    <= 1'b0;
    end else begin
      if (ctl.done_sample) begin
        prev_r <= mem_r;
      end
      if (cfg_load) begin
        power_r <= cfg_power;
      end else if (ctl.done_tick) begin
        power_r <= power_nxt;
      end
      if (ctl.bias) begin
        up_r <= up_c;
        dn_r <= dn_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pre) begin
      pa_r <= $signed({1'b0, LP_A}) * prev_r;
    end
    if (ctl.lpm) begin
      pb_r <= $signed({1'b0, LP_B}) * x_c;
    end
    if (ctl.lps) begin
      mem_r <= mem_c;
    end
  end

  a_prev_only_on_sample: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.done_sample |=> $stable(prev_r))
    else $error("filter memory moved outside a sample completion");

  a_power_step_one: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.done_tick && !cfg_load) |=> (power_r == $past(power_r)) ||
      (power_r == $past(power_r) + 1'b1) || (power_r == $past(power_r) - 1'b1))
    else $error("red power moved by more than one step on a tick");

endmodule

// ===== src/ppg_dc_removal_lowpass_bias.sv =====
// Top level: PPG DC removal, low-pass beat filter and red LED bias follower.
`timescale 1ns / 1ps
// Two DC-removal lanes (IR, red) run side by side, then a merge stage does the
// low-pass and the bias check. A sample goes from accept to result register
// through partial products, level update, AC rounding, low-pass product,
// low-pass sum, then output load. A bias tick goes through a compare, then a
// power step. One item is in flight at a time; input ready returns the cycle
// after the result is loaded. The result load waits while the output register
// holds a beat the sink has not taken. Config writes are always accepted; write
// red_power_start also reloads the current red power code.
module ppg_dc_removal_lowpass_bias #(
  parameter int LEVEL_FRAC_BITS = 16,
  parameter int POWER_BITS      = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  ppgdc_in_if.sink    in_ch,
  ppgdc_out_if.source out_ch,
  ppgdc_cfg_if.sink   cfg_ch
);
  import ppgdc_pkg::*;

  localparam int LB = LEVEL_INT_W + LEVEL_FRAC_BITS;

  state_t                  state_r, state_nxt;
  cmd_t                    cmd_r;
  logic [RAW_W-1:0]        ir_raw_r;
  logic [RAW_W-1:0]        red_raw_r;
  logic [ALPHA_W-1:0]      alpha_r;
  logic [THR_W-1:0]        thr_r;
  logic [POWER_BITS-1:0]   pmax_r;

  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_ir_ac_r;
  logic signed [OUT_W-1:0] out_red_ac_r;
  logic signed [OUT_W-1:0] out_filt_r;
  logic [POWER_BITS-1:0]   out_power_r;
  logic                    out_chg_r;

  lane_ctl_t               lane_ctl;
  merge_ctl_t              mctl;
  logic                    in_acc;
  logic                    cfg_acc;
  logic                    cfg_load;
  logic                    out_free;
  logic [LB-1:0]           ir_level;
  logic [LB-1:0]           red_level;
  logic signed [OUT_W-1:0] ir_ac;
  logic signed [OUT_W-1:0] red_ac;
  logic signed [OUT_W-1:0] filt;
  logic [POWER_BITS-1:0]   power_nxt;
  logic                    changed;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;
  assign cfg_load     = cfg_acc && (cfg_reg_t'(cfg_ch.idx) == REG_RED_POWER_START);
  assign out_free     = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    lane_ctl  = '0;
    mctl      = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (cmd_t'(in_ch.command) == CMD_TICK) ? ST_BIAS : ST_MUL;
        end
      end
      ST_MUL: begin
        lane_ctl.mul = 1'b1;
        mctl.pre     = 1'b1;
        state_nxt    = ST_LVL;
      end
      ST_LVL: begin
        lane_ctl.lvl = 1'b1;
        state_nxt    = ST_AC;
      end
      ST_AC: begin
        lane_ctl.ac = 1'b1;
        state_nxt   = ST_LPM;
      end
      ST_LPM: begin
        mctl.lpm  = 1'b1;
        state_nxt = ST_LPS;
      end
      ST_LPS: begin
        mctl.lps  = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_BIAS: begin
        mctl.bias = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          mctl.done_sample = (cmd_r == CMD_SAMPLE);
          mctl.done_tick   = (cmd_r == CMD_TICK);
          state_nxt        = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r     <= cmd_t'(in_ch.command);
      ir_raw_r  <= in_ch.ir_raw;
      red_raw_r <= in_ch.red_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RST;
      thr_r   <= THR_RST;
      pmax_r  <= POWER_BITS'(POWER_MAX_RST);
    end else if (cfg_acc) begin
      unique case (cfg_reg_t'(cfg_ch.idx))
        REG_DC_ALPHA:       alpha_r <= cfg_ch.data[ALPHA_W-1:0];
        REG_BIAS_THRESHOLD: thr_r   <= cfg_ch.data[THR_W-1:0];
        REG_RED_POWER_MAX:  pmax_r  <= cfg_ch.data[POWER_BITS-1:0];
        default: ;
      endcase
    end
  end

  ppgdc_dc_lane #(.LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)) u_ir_lane (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (lane_ctl),
    .alpha (alpha_r),
    .raw   (ir_raw_r),
    .level (ir_level),
    .ac    (ir_ac)
  );

  ppgdc_dc_lane #(.LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)) u_red_lane (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (lane_ctl),
    .alpha (alpha_r),
    .raw   (red_raw_r),
    .level (red_level),
    .ac    (red_ac)
  );

  ppgdc_merge #(
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS),
    .POWER_BITS      (POWER_BITS)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (mctl),
    .ir_ac     (ir_ac),
    .ir_level  (ir_level),
    .red_level (red_level),
    .thr       (thr_r),
    .power_max (pmax_r),
    .cfg_load  (cfg_load),
    .cfg_power (cfg_ch.data[POWER_BITS-1:0]),
    .filt      (filt),
    .power_nxt (power_nxt),
    .changed   (changed)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (mctl.done_sample || mctl.done_tick) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // ticks report zero AC and filter values
  always_ff @(posedge clk) begin
    if (mctl.done_sample || mctl.done_tick) begin
      out_ir_ac_r  <= mctl.done_sample ? ir_ac  : '0;
      out_red_ac_r <= mctl.done_sample ? red_ac : '0;
      out_filt_r   <= mctl.done_sample ? filt   : '0;
      out_power_r  <= power_nxt;
      out_chg_r    <= changed;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.ir_ac         = out_ir_ac_r;
  assign out_ch.red_ac        = out_red_ac_r;
  assign out_ch.beat_filtered = out_filt_r;
  assign out_ch.red_led_power = out_power_r;
  assign out_ch.power_changed = out_chg_r;

  a_sample_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (cmd_t'(in_ch.command) == CMD_SAMPLE)) |-> ##6 (state_r == ST_DONE))
    else $error("sample did not reach completion in six cycles");

  a_tick_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (cmd_t'(in_ch.command) == CMD_TICK)) |-> ##2 (state_r == ST_DONE))
    else $error("bias tick did not reach completion in two cycles");

  a_change_on_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_chg_r) |-> ((out_ir_ac_r == '0) && (out_red_ac_r == '0) &&
      (out_filt_r == '0)))
    else $error("power change reported on a sample beat");

endmodule

// ===== sim/tb_ppg_dc_removal_lowpass_bias.sv =====
// Testbench: directed and random sample/tick beats checked against a built-in predictor.
`timescale 1ns / 1ps
module tb_ppg_dc_removal_lowpass_bias;
  import ppgdc_pkg::*;

  localparam int LVL_FRAC = 16;
  localparam int LVL_W = LEVEL_INT_W + LVL_FRAC;
  localparam logic [63:0] LVL_TOP = (64'd1 << LVL_W) - 64'd1;
  localparam longint MEM_HI = 64'sd2147483647;
  localparam longint MEM_LO = -64'sd2147483648;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned TICK_PCT = 20;
  localparam int unsigned BURST_LEN = 24;

  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_SRC_GAPS,
    FLOW_SINK_STALLS,
    FLOW_BOTH
  } flow_t;

  typedef enum logic [2:0] {
    RAW_HIGH,
    RAW_LOW,
    RAW_ANY,
    RAW_EDGE,
    RAW_TOP
  } raw_style_t;

  typedef struct packed {
    logic signed [25:0] ir_ac;
    logic signed [25:0] red_ac;
    logic signed [25:0] beat;
    logic [3:0]         power;
    logic               changed;
  } ppg_result_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] ir;
    logic [15:0] red;
    logic        known;
    ppg_result_t want;
  } beat_row_t;

  typedef struct packed {
    logic [15:0] alpha;
    logic [23:0] thr;
    logic [3:0]  pmax;
    logic [3:0]  pstart;
    flow_t       flow;
    logic        full_scale;
    int unsigned beats;
  } run_phase_t;

  localparam ppg_result_t COMPUTED = '0;
  localparam ppg_result_t IDLE_AT_RESET = '{26'sd0, 26'sd0, 26'sd0, 4'(POWER_START_RST), 1'b0};

  localparam beat_row_t DIRECTED_BEATS [25] = '{
    '{CMD_TICK,   16'h0000, 16'h0000, 1'b1, IDLE_AT_RESET},
    '{CMD_SAMPLE, 16'h0000, 16'h0000, 1'b1, IDLE_AT_RESET},
    '{CMD_SAMPLE, 16'hFFFF, 16'h0000, 1'b0, COMPUTED},
    '{CMD_SAMPLE, 16'h0000, 16'hFFFF, 1'b0, COMPUTED},
    '{CMD_SAMPLE, 16'hFFFF, 16'hFFFF, 1'b0, COMPUTED},
    '{CMD_SAMPLE, 16'h8000, 16'h7FFF, 1'b0, COMPUTED},
    '{CMD_SAMPLE, 16'h5555, 16'hAAAA, 1'b0, COMPUTED},
    '{CMD_SAMPLE, 16'hAAAA, 16'h5555, 1'b0, COMPUTED},
    '{CMD_SAMPLE, 16'hFFFF, 16'h0000, 1'b0, COMPUTED},
    '{CMD_SAMPLE, 16'hFFFF, 16'h0000, 1'b0, COMPUTED},
    '{CMD_SAMPLE, 16'hFFFF, 16'h0000, 1'b0, COMPUTED},
    '{CMD_SAMPLE, 16'hFFFF, 16'h0000, 1'b0, COMPUTED},
    '{CMD_TICK,   16'h0000, 16'h0000, 1'b0, COMPUTED},
    '{CMD_TICK,   16'h0000, 16'h0000, 1'b0, COMPUTED},
    '{CMD_SAMPLE, 16'h0000, 16'hFFFF, 1'b0, COMPUTED},
    '{CMD_SAMPLE, 16'h0000, 16'hFFFF, 1'b0, COMPUTED},
    '{CMD_SAMPLE, 16'h0000, 16'hFFFF, 1'b0, COMPUTED},
    '{CMD_SAMPLE, 16'h0000, 16'hFFFF, 1'b0, COMPUTED},
    '{CMD_SAMPLE, 16'h0000, 16'hFFFF, 1'b0, COMPUTED},
    '{CMD_SAMPLE, 16'h0000, 16'hFFFF, 1'b0, COMPUTED},
    '{CMD_TICK,   16'h0000, 16'h0000, 1'b0, COMPUTED},
    '{CMD_TICK,   16'h0000, 16'h0000, 1'b0, COMPUTED},
    '{CMD_TICK,   16'h1234, 16'hFEDC, 1'b0, COMPUTED},
    '{CMD_SAMPLE, 16'h0001, 16'h0001, 1'b0, COMPUTED},
    '{CMD_SAMPLE, 16'h7FFF, 16'h8000, 1'b0, COMPUTED}
  };

  logic clk;
  logic rst_n;

  ppgdc_in_if  in_if ();
  ppgdc_out_if #(.POWER_BITS(4)) out_if ();
  ppgdc_cfg_if cfg_if ();

  ppg_dc_removal_lowpass_bias DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // predictor copy of settings and filter state
  logic [15:0]      cf_alpha;
  logic [23:0]      cf_thr;
  logic [3:0]       cf_pmax;
  logic [3:0]       cf_pstart;
  logic [LVL_W-1:0] lvl_ir;
  logic [LVL_W-1:0] lvl_red;
  int               lp_mem;
  logic [3:0]       pwr_code;

  ppg_result_t      expected_results [$];
  ppg_result_t      want;
  logic             row_known;
  ppg_result_t      row_want;
  int unsigned      src_gap_pct;
  int unsigned      sink_stall_pct;
  int unsigned      mismatches;
  int unsigned      results_seen;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic signed [25:0] sat26(longint v);
    if (v > OUT_MAX) return 26'(OUT_MAX);
    if (v < OUT_MIN) return 26'(OUT_MIN);
    return 26'(v);
  endfunction

  function automatic logic signed [25:0] dc_track(inout logic [LVL_W-1:0] level,
                                                  input logic [15:0] raw);
    logic [63:0] prod;
    logic [63:0] nxt;
    longint      diff;
    prod = (64'(cf_alpha) * 64'(level) + 64'h8000) >> 16;
    nxt = (64'(raw) << LVL_FRAC) + prod;
    if (nxt > LVL_TOP) nxt = LVL_TOP;
    diff = longint'(nxt) - longint'(64'(level));
    level = nxt[LVL_W-1:0];
    return sat26((diff + (64'sd1 << (LVL_FRAC - OUT_FRAC - 1))) >>> (LVL_FRAC - OUT_FRAC));
  endfunction

  function automatic ppg_result_t next_ppg_result(cmd_t c, logic [15:0] ir, logic [15:0] red);
    ppg_result_t      r;
    longint           x;
    longint           m;
    logic [LVL_W-1:0] thr_lvl;
    r = '0;
    if (c == CMD_SAMPLE) begin
      r.ir_ac = dc_track(lvl_ir, ir);
      r.red_ac = dc_track(lvl_red, red);
      x = -longint'(r.ir_ac);
      if (x > OUT_MAX) x = OUT_MAX;
      m = (longint'(LP_B) * x + longint'(LP_A) * longint'(lp_mem) + 64'sd32768) >>> COEF_FRAC;
      if (m > MEM_HI) m = MEM_HI;
      if (m < MEM_LO) m = MEM_LO;
      r.beat = sat26(longint'(lp_mem) + m);
      lp_mem = int'(m);
    end else begin
      thr_lvl = {cf_thr, {LVL_FRAC{1'b0}}};
      if (lvl_ir > lvl_red && lvl_ir - lvl_red > thr_lvl && pwr_code < cf_pmax) begin
        pwr_code = pwr_code + 4'd1;
        r.changed = 1'b1;
      end else if (lvl_red > lvl_ir && lvl_red - lvl_ir > thr_lvl && pwr_code > 4'd0) begin
        pwr_code = pwr_code - 4'd1;
        r.changed = 1'b1;
      end
    end
    r.power = pwr_code;
    return r;
  endfunction

  function automatic void apply_setting(logic [7:0] idx, logic [23:0] data);
    case (idx)
      REG_DC_ALPHA:       cf_alpha = data[15:0];
      REG_BIAS_THRESHOLD: cf_thr = data;
      REG_RED_POWER_MAX:  cf_pmax = data[3:0];
      REG_RED_POWER_START: begin
        cf_pstart = data[3:0];
        pwr_code = data[3:0];
      end
      default: ;
    endcase
  endfunction

  function automatic logic [15:0] pick_raw(raw_style_t style);
    case (style)
      RAW_HIGH: return 16'($urandom_range(49152, 65535));
      RAW_LOW:  return 16'($urandom_range(0, 16383));
      RAW_ANY:  return 16'($urandom);
      RAW_TOP:  return 16'($urandom_range(65280, 65535));
      default: begin
        case ($urandom_range(0, 2))
          0:       return 16'h0000;
          1:       return 16'hFFFF;
          default: return 16'($urandom);
        endcase
      end
    endcase
  endfunction

  task automatic log_mismatch(string what);
    if (mismatches < 100) $display("MISMATCH result %0d: %s", results_seen, what);
    mismatches++;
  endtask

  task automatic check_field(string name, logic signed [31:0] got, logic signed [31:0] exp_v);
    if (got !== exp_v) log_mismatch($sformatf("%s got %0d expected %0d", name, got, exp_v));
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) apply_setting(cfg_if.idx, cfg_if.data);
      if (in_if.valid && in_if.ready) begin
        want = next_ppg_result(cmd_t'(in_if.command), in_if.ir_raw, in_if.red_raw);
        if (row_known) want = row_want;
        expected_results.push_back(want);
      end
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          log_mismatch("result beat with nothing expected");
        end else begin
          want = expected_results.pop_front();
          check_field("ir_ac", out_if.ir_ac, want.ir_ac);
          check_field("red_ac", out_if.red_ac, want.red_ac);
          check_field("beat_filtered", out_if.beat_filtered, want.beat);
          check_field("red_led_power", {28'd0, out_if.red_led_power}, {28'd0, want.power});
          check_field("power_changed", {31'd0, out_if.power_changed}, {31'd0, want.changed});
        end
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      out_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic set_flow(flow_t f);
    case (f)
      FLOW_FREE:        begin src_gap_pct = 0;  sink_stall_pct = 0;  end
      FLOW_SRC_GAPS:    begin src_gap_pct = 49; sink_stall_pct = 0;  end
      FLOW_SINK_STALLS: begin src_gap_pct = 0;  sink_stall_pct = 49; end
      default:          begin src_gap_pct = 22; sink_stall_pct = 22; end
    endcase
  endtask

  // starts and returns at a falling edge; valid stays high for the caller
  task automatic push_beat(cmd_t c, logic [15:0] ir, logic [15:0] red);
    while ($urandom_range(0, 99) < src_gap_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.command <= c;
    in_if.ir_raw <= ir;
    in_if.red_raw <= red;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [23:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.idx <= idx;
    cfg_if.data <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    while (expected_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : stimulus
    run_phase_t plan [6];
    run_phase_t p;
    raw_style_t ir_style;
    raw_style_t red_style;

    cf_alpha = ALPHA_RST;
    cf_thr = THR_RST;
    cf_pmax = 4'(POWER_MAX_RST);
    cf_pstart = 4'(POWER_START_RST);
    lvl_ir = '0;
    lvl_red = '0;
    lp_mem = 0;
    pwr_code = cf_pstart;
    row_known = 1'b0;
    row_want = '0;
    mismatches = 0;
    results_seen = 0;
    src_gap_pct = 0;
    sink_stall_pct = 0;
    ir_style = RAW_ANY;
    red_style = RAW_ANY;

    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.command <= CMD_SAMPLE;
    in_if.ir_raw <= '0;
    in_if.red_raw <= '0;
    out_if.ready <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.idx <= '0;
    cfg_if.data <= '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_flow(FLOW_FREE);
    foreach (DIRECTED_BEATS[i]) begin
      row_known = DIRECTED_BEATS[i].known;
      row_want = DIRECTED_BEATS[i].want;
      push_beat(DIRECTED_BEATS[i].cmd, DIRECTED_BEATS[i].ir, DIRECTED_BEATS[i].red);
    end
    in_if.valid <= 1'b0;
    row_known = 1'b0;

    // saturating levels, power pinned at max, then the other extremes
    plan[0] = '{16'hFFFF, 24'd0,        4'd15, 4'd15, FLOW_FREE,        1'b1, 400};
    plan[1] = '{16'h0000, 24'hFFFFFF,   4'd0,  4'd0,  FLOW_SRC_GAPS,    1'b0, 200};
    plan[2] = '{16'h8000, 24'd1000,     4'd5,  4'd12, FLOW_SINK_STALLS, 1'b0, 350};
    plan[3] = '{ALPHA_RST, THR_RST,     4'd15, 4'd8,  FLOW_BOTH,        1'b0, 300};
    plan[4] = '{16'($urandom), 24'($urandom_range(0, 200000)), 4'($urandom),
                4'($urandom), flow_t'($urandom_range(0, 3)), 1'b0, 300};
    plan[5] = '{16'd65000, 24'd50000,   4'd10, 4'd3,  FLOW_SRC_GAPS,    1'b0, 300};

    foreach (plan[k]) begin
      p = plan[k];
      drain_results();
      write_reg(REG_DC_ALPHA, {8'($urandom), p.alpha});
      write_reg(REG_BIAS_THRESHOLD, p.thr);
      write_reg(REG_RED_POWER_MAX, {20'($urandom), p.pmax});
      write_reg(8'($urandom_range(4, 255)), 24'($urandom));
      write_reg(REG_RED_POWER_START, {20'($urandom), p.pstart});
      cfg_if.valid <= 1'b0;
      set_flow(p.flow);
      for (int n = 0; n < p.beats; n++) begin
        if (n % BURST_LEN == 0) begin
          case ($urandom_range(0, 3))
            0:       begin ir_style = RAW_HIGH; red_style = RAW_LOW;  end
            1:       begin ir_style = RAW_LOW;  red_style = RAW_HIGH; end
            2:       begin ir_style = RAW_ANY;  red_style = RAW_ANY;  end
            default: begin ir_style = RAW_EDGE; red_style = RAW_EDGE; end
          endcase
          if (p.full_scale) begin
            ir_style = RAW_TOP;
            red_style = RAW_TOP;
          end
        end
        if ($urandom_range(0, 99) < TICK_PCT) begin
          push_beat(CMD_TICK, 16'($urandom), 16'($urandom));
        end else begin
          push_beat(CMD_SAMPLE, pick_raw(ir_style), pick_raw(red_style));
        end
      end
      in_if.valid <= 1'b0;
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/ppgdc_pkg.sv
src/ppgdc_in_if.sv
src/ppgdc_out_if.sv
src/ppgdc_cfg_if.sv
src/ppgdc_dc_lane.sv
src/ppgdc_merge.sv
src/ppg_dc_removal_lowpass_bias.sv
sim/tb_ppg_dc_removal_lowpass_bias.sv
